// ===== hdl/uarttxq_pkg.sv =====
package uarttxq_pkg;

  // slot life cycle
  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_READY = 2'd1,
    ST_BUSY  = 2'd2,
    ST_FILL  = 2'd3
  } slot_status_t;

  // input word kinds, carried on tuser
  localparam logic ACT_BYTE     = 1'b0;
  localparam logic ACT_TX_EMPTY = 1'b1;

  localparam int unsigned OUT_SLOT_W = 2;
  localparam int unsigned BYTE_W     = 8;

  // result word, lowest field last so that accepted sits in bit 0
  typedef struct packed {
    logic                  tx_int_enable;
    logic                  freed;
    logic [BYTE_W-1:0]     tx_byte;
    logic                  tx_valid;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  rejected;
    logic                  accepted;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== hdl/uarttxq_ram.sv =====
module uarttxq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/uart_tx_buffer_pool_queue.sv =====
// Transmit message queue over a pool of NUM_SLOTS buffers of SLOT_BYTES bytes each.
// Input channel (s_*): s_tuser = 0 carries one message byte in s_tdata[7:0], with
// s_tlast on the final byte of the message; s_tuser = 1 is a transmitter-empty
// event, the byte lanes are ignored. The first byte of a message takes the lowest
// free slot; with no free slot the message is dropped and flagged rejected on its
// last byte. Bytes past SLOT_BYTES are discarded. Each event returns the next byte
// of the head message, or frees the head slot once its bytes are all sent.
// Output channel (m_*): exactly one word per input word, in order.
// Each result is registered in a first stage and then in the output stage that drives
// m_tdata; the extra stage covers the registered RAM read.
// Throughput: one word per cycle, both channels, as long as m_tready does not stall the
// output; set by the single RAM read port and the combinational slot search.
// Reset clears slot states, queue pointers and both pipeline stages; buffer
// contents, lengths and links are not cleared and are only read once written.
// When m_tready is low the output word holds, the stage in front of it fills,
// and s_tready drops only once both stages are occupied.
module uart_tx_buffer_pool_queue #(
  parameter int unsigned NUM_SLOTS  = 4,
  parameter int unsigned SLOT_BYTES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // data_byte
  input  logic                         s_tlast,  // last_byte
  input  logic                         s_tuser,  // action
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // accepted, rejected, slot[1:0], tx_valid, tx_byte[7:0], freed, tx_int_enable, pad
  output logic [uarttxq_pkg::M_DATA_W-1:0] m_tdata
);
  import uarttxq_pkg::*;

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOT_BYTES + 1);
  localparam int unsigned DEPTH  = NUM_SLOTS * SLOT_BYTES;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  slot_status_t            status      [NUM_SLOTS];
  slot_status_t            status_next [NUM_SLOTS];
  logic [CNT_W-1:0]        len         [NUM_SLOTS];
  logic [CNT_W-1:0]        len_next    [NUM_SLOTS];
  logic [SLOT_W-1:0]       link        [NUM_SLOTS];
  logic [SLOT_W-1:0]       link_next   [NUM_SLOTS];
  logic [SLOT_W-1:0]       head, head_next;
  logic [SLOT_W-1:0]       tail, tail_next;
  logic                    queue_nonempty, queue_nonempty_next;
  logic [CNT_W-1:0]        sent_count, sent_count_next;
  logic [SLOT_W-1:0]       fill_slot, fill_slot_next;
  logic [CNT_W-1:0]        fill_count, fill_count_next;
  logic                    filling, filling_next;
  logic                    dropping, dropping_next;

  logic                    accept;
  logic                    a_valid;
  result_t                 a_res, res;
  result_t                 a_out;
  logic                    a_adv;
  logic                    b_ready;
  logic                    b_valid;
  result_t                 b_res;

  logic                    wr_en, rd_en;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic [BYTE_W-1:0]       rd_data;
  logic                    found;
  logic [SLOT_W-1:0]       free_idx;
  logic                    any_queued;

  function automatic logic [ADDR_W-1:0] buf_addr(input logic [SLOT_W-1:0] s,
                                                 input logic [CNT_W-1:0] c);
    buf_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(c));
  endfunction

  function automatic logic [OUT_SLOT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+OUT_SLOT_W-1:0] wide;
    wide = {{OUT_SLOT_W{1'b0}}, s};
    slot_out = wide[OUT_SLOT_W-1:0];
  endfunction

  assign b_ready  = !b_valid || m_tready;
  assign a_adv    = a_valid && b_ready;
  assign s_tready = !a_valid || b_ready;
  assign accept   = s_tvalid && s_tready;

  // lowest-numbered empty slot
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (status[i] == ST_EMPTY) begin
        found    = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    logic [SLOT_W-1:0] fs;
    logic [CNT_W-1:0]  fc;
    logic              fl;
    logic              dr;
    status_next         = status;
    len_next            = len;
    link_next           = link;
    head_next           = head;
    tail_next           = tail;
    queue_nonempty_next = queue_nonempty;
    sent_count_next     = sent_count;
    fill_slot_next      = fill_slot;
    fill_count_next     = fill_count;
    filling_next        = filling;
    dropping_next       = dropping;
    res                 = '0;
    wr_en               = 1'b0;
    wr_addr             = '0;
    rd_en               = 1'b0;
    rd_addr             = buf_addr(head, sent_count);
    fs                  = fill_slot;
    fc                  = fill_count;
    fl                  = filling;
    dr                  = dropping;
    if (accept) begin
      if (s_tuser == ACT_BYTE) begin
        if (!fl && !dr) begin
          if (found) begin
            fl                    = 1'b1;
            fs                    = free_idx;
            fc                    = '0;
            status_next[free_idx] = ST_FILL;
          end else begin
            dr = 1'b1;
          end
        end
        if (fl) begin
          if (fc < CNT_W'(SLOT_BYTES)) begin
            wr_en   = 1'b1;
            wr_addr = buf_addr(fs, fc);
            fc      = CNT_W'(fc + 1'b1);
          end
          if (s_tlast) begin
            len_next[fs]    = fc;
            status_next[fs] = ST_READY;
            if (queue_nonempty) begin
              link_next[tail] = fs;
            end else begin
              head_next           = fs;
              sent_count_next     = '0;
              queue_nonempty_next = 1'b1;
            end
            tail_next    = fs;
            res.accepted = 1'b1;
            res.slot     = slot_out(fs);
            fl           = 1'b0;
            fc           = '0;
          end
        end else if (s_tlast) begin
          res.rejected = 1'b1;
          dr           = 1'b0;
        end
        fill_slot_next  = fs;
        fill_count_next = fc;
        filling_next    = fl;
        dropping_next   = dr;
      end else if (queue_nonempty) begin
        if (sent_count < len[head]) begin
          status_next[head] = ST_BUSY;
          res.tx_valid      = 1'b1;
          rd_en             = 1'b1;
          sent_count_next   = CNT_W'(sent_count + 1'b1);
        end else begin
          // head message done: free its slot and move on
          status_next[head] = ST_EMPTY;
          res.freed         = 1'b1;
          res.slot          = slot_out(head);
          sent_count_next   = '0;
          if (head == tail) begin
            queue_nonempty_next = 1'b0;
          end else begin
            head_next = link[head];
          end
        end
      end
      res.tx_int_enable = queue_nonempty_next;
    end
  end

  uarttxq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status[i] <= ST_EMPTY;
      end
      head           <= '0;
      tail           <= '0;
      queue_nonempty <= 1'b0;
      sent_count     <= '0;
      fill_slot      <= '0;
      fill_count     <= '0;
      filling        <= 1'b0;
      dropping       <= 1'b0;
      a_valid        <= 1'b0;
      b_valid        <= 1'b0;
    end else begin
      status         <= status_next;
      head           <= head_next;
      tail           <= tail_next;
      queue_nonempty <= queue_nonempty_next;
      sent_count     <= sent_count_next;
      fill_slot      <= fill_slot_next;
      fill_count     <= fill_count_next;
      filling        <= filling_next;
      dropping       <= dropping_next;
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        b_valid <= 1'b1;
      end else if (m_tready) begin
        b_valid <= 1'b0;
      end
    end
  end

  // ram read data holds until the next word is taken in
  always_comb begin
    a_out         = a_res;
    a_out.tx_byte = a_res.tx_valid ? rd_data : '0;
  end

  // lengths, links and result payloads need no reset
  always_ff @(posedge clk) begin
    len  <= len_next;
    link <= link_next;
    if (accept) begin
      a_res <= res;
    end
    if (a_adv) begin
      b_res <= a_out;
    end
  end

  assign m_tvalid = b_valid;
  assign m_tdata  = M_DATA_W'(b_res);

  always_comb begin
    any_queued = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (status[i] == ST_READY || status[i] == ST_BUSY) begin
        any_queued = 1'b1;
      end
    end
  end

  a_fill_drop_excl: assert property (@(posedge clk) disable iff (rst)
    !(filling && dropping))
    else $error("filling and dropping at once");

  a_empty_queue: assert property (@(posedge clk) disable iff (rst)
    !queue_nonempty |-> !any_queued)
    else $error("slot queued while queue is empty");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> !((a_res.accepted || a_res.rejected) && (a_res.tx_valid || a_res.freed)))
    else $error("byte and event results mixed in one word");

  a_idle_event: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == ACT_TX_EMPTY && !queue_nonempty
      |=> !a_res.tx_valid && !a_res.freed && !a_res.tx_int_enable)
    else $error("event on empty queue produced output");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_res.tx_valid |-> b_res.tx_byte == '0)
    else $error("tx byte set without tx valid");

endmodule

// ===== tb/uart_tx_buffer_pool_queue_tb.sv =====
`timescale 1ns / 100ps

module uart_tx_buffer_pool_queue_tb;
  import uarttxq_pkg::*;

  localparam int unsigned NUM_SLOTS  = 4;
  localparam int unsigned SLOT_BYTES = 64;
  localparam int unsigned N_RANDOM   = 2000;
  localparam int unsigned HOLD_LEN   = 60;
  localparam int unsigned LIMIT      = 300000;
  localparam int unsigned N_ROWS     = 17;

  typedef struct {
    logic        act;
    logic [7:0]  b;
    logic        lst;
    int unsigned rep;
    bit          typed;
    result_t     want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic s_tuser = ACT_BYTE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // shadow of the slot pool
  logic [7:0]     buf_mem [NUM_SLOTS*SLOT_BYTES];
  slot_status_t   slot_st [NUM_SLOTS];
  int unsigned    msg_len [NUM_SLOTS];
  int unsigned    next_link [NUM_SLOTS];
  int unsigned    head_idx = 0;
  int unsigned    tail_idx = 0;
  bit             q_busy = 1'b0;
  int unsigned    sent_cnt = 0;
  int unsigned    fill_idx = 0;
  int unsigned    fill_cnt = 0;
  bit             in_fill = 1'b0;
  bit             in_drop = 1'b0;

  result_t        pending_results [$];
  int unsigned    err_count = 0;
  int unsigned    cycles = 0;
  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    hold_req = 0;
  int unsigned    hold_ack = 0;
  int unsigned    hold_left = 0;
  row_t           dir_rows [N_ROWS];

  uart_tx_buffer_pool_queue #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_BYTES(SLOT_BYTES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL uart_tx_buffer_pool_queue");
      $finish;
    end
  end

  function automatic result_t res_word(bit acc, bit rej, logic [1:0] sl, bit txv,
                                       logic [7:0] txb, bit fr, bit ie);
    result_t r;
    r = '0;
    r.accepted      = acc;
    r.rejected      = rej;
    r.slot          = sl;
    r.tx_valid      = txv;
    r.tx_byte       = txb;
    r.freed         = fr;
    r.tx_int_enable = ie;
    return r;
  endfunction

  function automatic result_t queue_step(logic act, logic [7:0] b, logic lst);
    result_t r;
    int unsigned h;
    bit found;
    r = '0;
    if (act == ACT_BYTE) begin
      if (!in_fill && !in_drop) begin
        found = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!found && slot_st[s] == ST_EMPTY) begin
            found = 1'b1;
            fill_idx = s;
          end
        end
        if (found) begin
          in_fill = 1'b1;
          fill_cnt = 0;
          slot_st[fill_idx] = ST_FILL;
        end else begin
          in_drop = 1'b1;
        end
      end
      if (in_fill) begin
        // bytes past the slot size are lost, length saturates
        if (fill_cnt < SLOT_BYTES) begin
          buf_mem[fill_idx*SLOT_BYTES + fill_cnt] = b;
          fill_cnt++;
        end
        if (lst) begin
          msg_len[fill_idx] = fill_cnt;
          slot_st[fill_idx] = ST_READY;
          if (q_busy) begin
            next_link[tail_idx] = fill_idx;
          end else begin
            head_idx = fill_idx;
            sent_cnt = 0;
            q_busy = 1'b1;
          end
          tail_idx = fill_idx;
          r.accepted = 1'b1;
          r.slot = 2'(fill_idx);
          in_fill = 1'b0;
          fill_cnt = 0;
        end
      end else if (lst) begin
        r.rejected = 1'b1;
        in_drop = 1'b0;
      end
    end else if (q_busy) begin
      h = head_idx;
      if (sent_cnt < msg_len[h] && sent_cnt < SLOT_BYTES) begin
        slot_st[h] = ST_BUSY;
        r.tx_valid = 1'b1;
        r.tx_byte = buf_mem[h*SLOT_BYTES + sent_cnt];
        sent_cnt++;
      end else begin
        slot_st[h] = ST_EMPTY;
        r.freed = 1'b1;
        r.slot = 2'(h);
        sent_cnt = 0;
        if (h == tail_idx) q_busy = 1'b0;
        else head_idx = next_link[h] % NUM_SLOTS;
      end
    end
    r.tx_int_enable = q_busy;
    return r;
  endfunction

  task automatic push_word(logic act, logic [7:0] b, logic lst, bit typed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= b;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = queue_step(act, b, lst);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic check_word(result_t got);
    result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("result word %h with nothing expected", got);
      err_count++;
    end else begin
      exp_r = pending_results.pop_front();
      if (got.accepted !== exp_r.accepted) begin
        $error("accepted: expected %0d, got %0d", exp_r.accepted, got.accepted);
        err_count++;
      end
      if (got.rejected !== exp_r.rejected) begin
        $error("rejected: expected %0d, got %0d", exp_r.rejected, got.rejected);
        err_count++;
      end
      if (got.slot !== exp_r.slot) begin
        $error("slot: expected %0d, got %0d", exp_r.slot, got.slot);
        err_count++;
      end
      if (got.tx_valid !== exp_r.tx_valid) begin
        $error("tx_valid: expected %0d, got %0d", exp_r.tx_valid, got.tx_valid);
        err_count++;
      end
      if (got.tx_byte !== exp_r.tx_byte) begin
        $error("tx_byte: expected %h, got %h", exp_r.tx_byte, got.tx_byte);
        err_count++;
      end
      if (got.freed !== exp_r.freed) begin
        $error("freed: expected %0d, got %0d", exp_r.freed, got.freed);
        err_count++;
      end
      if (got.tx_int_enable !== exp_r.tx_int_enable) begin
        $error("tx_int_enable: expected %0d, got %0d", exp_r.tx_int_enable,
               got.tx_int_enable);
        err_count++;
      end
    end
  endtask

  // output side: check, then choose the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_word(result_t'(m_tdata[RESULT_W-1:0]));
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_ack + 1;
      hold_left <= HOLD_LEN;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int unsigned msg_left;
    int unsigned ev_pct;
    int unsigned phase;
    int unsigned pick;

    for (int s = 0; s < NUM_SLOTS; s++) slot_st[s] = ST_EMPTY;
    msg_left = 0;
    ev_pct = 50;

    // the pool: slots 0..3 filled in order, a fifth message has no room
    dir_rows[0]  = '{ACT_TX_EMPTY, 8'hFF, 1'b1, 1, 1'b1,
                     res_word(1'b0, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir_rows[1]  = '{ACT_BYTE,     8'h00, 1'b0, 1, 1'b1,
                     res_word(1'b0, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, 1'b0)};
    dir_rows[2]  = '{ACT_BYTE,     8'hFF, 1'b1, 1, 1'b1,
                     res_word(1'b1, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, 1'b1)};
    dir_rows[3]  = '{ACT_BYTE,     8'hA5, 1'b1, 1, 1'b1,
                     res_word(1'b1, 1'b0, 2'd1, 1'b0, 8'h00, 1'b0, 1'b1)};
    dir_rows[4]  = '{ACT_BYTE,     8'h5A, 1'b0, 1, 1'b1,
                     res_word(1'b0, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, 1'b1)};
    dir_rows[5]  = '{ACT_BYTE,     8'h3C, 1'b1, 1, 1'b1,
                     res_word(1'b1, 1'b0, 2'd2, 1'b0, 8'h00, 1'b0, 1'b1)};
    dir_rows[6]  = '{ACT_BYTE,     8'h81, 1'b1, 1, 1'b1,
                     res_word(1'b1, 1'b0, 2'd3, 1'b0, 8'h00, 1'b0, 1'b1)};
    dir_rows[7]  = '{ACT_BYTE,     8'h11, 1'b0, 1, 1'b1,
                     res_word(1'b0, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, 1'b1)};
    dir_rows[8]  = '{ACT_BYTE,     8'h22, 1'b1, 1, 1'b1,
                     res_word(1'b0, 1'b1, 2'd0, 1'b0, 8'h00, 1'b0, 1'b1)};
    dir_rows[9]  = '{ACT_TX_EMPTY, 8'h00, 1'b0, 1, 1'b1,
                     res_word(1'b0, 1'b0, 2'd0, 1'b1, 8'h00, 1'b0, 1'b1)};
    dir_rows[10] = '{ACT_TX_EMPTY, 8'hFF, 1'b1, 1, 1'b1,
                     res_word(1'b0, 1'b0, 2'd0, 1'b1, 8'hFF, 1'b0, 1'b1)};
    dir_rows[11] = '{ACT_TX_EMPTY, 8'h00, 1'b0, 1, 1'b1,
                     res_word(1'b0, 1'b0, 2'd0, 1'b0, 8'h00, 1'b1, 1'b1)};
    // overlong message into the freed slot, with sending going on meanwhile
    dir_rows[12] = '{ACT_BYTE,     8'hC3, 1'b0, 70, 1'b0, '0};
    dir_rows[13] = '{ACT_TX_EMPTY, 8'h00, 1'b0, 1, 1'b0, '0};
    dir_rows[14] = '{ACT_BYTE,     8'h7E, 1'b1, 1, 1'b0, '0};
    dir_rows[15] = '{ACT_TX_EMPTY, 8'h5A, 1'b1, 140, 1'b0, '0};
    dir_rows[16] = '{ACT_TX_EMPTY, 8'hFF, 1'b0, 1, 1'b1,
                     res_word(1'b0, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0, 1'b0)};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].rep)
        push_word(dir_rows[r].act, dir_rows[r].b, dir_rows[r].lst, dir_rows[r].typed,
                  dir_rows[r].want);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 125 == 0) begin
        phase = (i / 125) % 4;
        case (phase)
          0: begin
            idle_pct = 0;
            stall_pct <= 0;
          end
          1: begin
            idle_pct = 78;
            stall_pct <= 0;
          end
          2: begin
            idle_pct = 0;
            stall_pct <= 78;
          end
          default: begin
            idle_pct = 11;
            stall_pct <= 11;
          end
        endcase
        // low event rates fill the pool and force rejects, high ones drain it
        case ($urandom_range(3))
          0: ev_pct = 8;
          1: ev_pct = 35;
          2: ev_pct = 55;
          default: ev_pct = 80;
        endcase
      end
      if (i == 510) hold_req <= hold_req + 1;
      if (i == 1010) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < ev_pct) begin
        push_word(ACT_TX_EMPTY, 8'($urandom), 1'($urandom), 1'b0, '0);
      end else begin
        if (msg_left == 0) begin
          pick = $urandom_range(99);
          if (pick < 85) msg_left = $urandom_range(6, 1);
          else if (pick < 95) msg_left = $urandom_range(SLOT_BYTES, 7);
          else msg_left = $urandom_range(SLOT_BYTES + 8, SLOT_BYTES + 1);
        end
        msg_left--;
        push_word(ACT_BYTE, 8'($urandom), msg_left == 0, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    stall_pct <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS uart_tx_buffer_pool_queue");
    end else begin
      $display("FAIL uart_tx_buffer_pool_queue");
    end
    $finish;
  end

endmodule
